### hdl/guid_keyed_chained_hash_table_assert.svh
// Assertion macros used by the hash table back end
`ifndef GUID_KEYED_CHAINED_HASH_TABLE_ASSERT_SVH
`define GUID_KEYED_CHAINED_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define GHCT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset
`define GHCT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/ghct_pkg.sv
package ghct_pkg;

	localparam int MAX_KEY_BITS = 12;
	localparam int ENTRY_COUNT  = 4096;
	localparam int HANDLE_BITS  = 16;
	localparam int KIND_BITS    = 3;
	localparam int BUCKET_BITS  = MAX_KEY_BITS;
	localparam int BUCKET_COUNT = 1 << MAX_KEY_BITS;
	localparam int ENTRY_BITS   = $clog2(ENTRY_COUNT);
	localparam int IDX_BITS     = ENTRY_BITS + 1;
	localparam int QUEUE_DEPTH  = 2;

	// Empty link / empty bucket marker
	localparam logic [IDX_BITS-1:0] NONE = IDX_BITS'(ENTRY_COUNT);

	localparam logic [63:0] MIX_C0 = 64'd16292676669999574021;
	localparam logic [63:0] MIX_C1 = 64'd10242350189706880077;
	localparam logic [63:0] MIX_C2 = 64'd12844332200329132887;
	localparam logic [63:0] MIX_C3 = 64'd16728792139623414127;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_RSVD   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]             opcode;
		logic [31:0]            guid_prefix_0;
		logic [31:0]            guid_prefix_1;
		logic [31:0]            guid_prefix_2;
		logic [31:0]            entity_word;
		logic [KIND_BITS-1:0]   obj_kind;
		logic [HANDLE_BITS-1:0] handle_in;
	} req_t;

	typedef struct packed {
		logic [1:0]             status;
		logic [HANDLE_BITS-1:0] handle_out;
		logic [BUCKET_BITS-1:0] bucket_out;
	} rsp_t;

	// Stored entry contents
	typedef struct packed {
		logic [63:0]            key_upper;
		logic [63:0]            key_lower;
		logic [KIND_BITS-1:0]   kind;
		logic [HANDLE_BITS-1:0] handle;
	} entry_t;

	// Classified request handed from front to back
	typedef struct packed {
		op_t                    op;
		entry_t                 ent;
		logic [BUCKET_BITS-1:0] bucket;
	} job_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_INS,
		S_HEAD,
		S_CMP,
		S_FREE,
		S_RESP
	} back_state_t;

endpackage

### hdl/ghct_front.sv
module ghct_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ghct_pkg::req_t in_data,
	input  logic          enable,
	input  logic [3:0]    key_bits,
	output logic          push,
	output ghct_pkg::job_t push_data,
	input  logic          full
);
	import ghct_pkg::*;

	logic                   v_s1, v_s2, v_s3;
	logic [63:0]            a_s1, b_s1, c_s1, d_s1;
	entry_t                 ent_s1, ent_s2, ent_s3;
	op_t                    op_s1, op_s2, op_s3;
	logic [63:0]            p0_ll_s2, p1_ll_s2;
	logic [31:0]            p0_x_s2, p1_x_s2;
	logic [BUCKET_BITS-1:0] top_s3;
	logic                   adv;
	logic [63:0]            m0_ll, m1_ll, hsum;
	logic [31:0]            m0_lh, m0_hl, m1_lh, m1_hl;
	logic [3:0]             eff, shamt;

	// Pipeline advances unless the last stage is blocked by a full queue
	assign adv      = !v_s3 || !full;
	assign in_ready = adv && enable;
	assign push     = v_s3 && !full;

	// Stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && in_ready;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: offset each word by its constant
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1   <= {32'h0, in_data.guid_prefix_0} + MIX_C0;
			b_s1   <= {32'h0, in_data.guid_prefix_1} + MIX_C1;
			c_s1   <= {32'h0, in_data.guid_prefix_2} + MIX_C2;
			d_s1   <= {32'h0, in_data.entity_word} + MIX_C3;
			op_s1  <= op_t'(in_data.opcode);
			ent_s1 <= '{key_upper: {in_data.guid_prefix_0, in_data.guid_prefix_1},
				key_lower: {in_data.guid_prefix_2, in_data.entity_word},
				kind: in_data.obj_kind, handle: in_data.handle_in};
		end
	end

	// Stage 2: 32x32 partial products, only low half of cross terms kept
	assign m0_ll = {32'h0, a_s1[31:0]} * {32'h0, b_s1[31:0]};
	assign m0_lh = a_s1[31:0] * b_s1[63:32];
	assign m0_hl = a_s1[63:32] * b_s1[31:0];
	assign m1_ll = {32'h0, c_s1[31:0]} * {32'h0, d_s1[31:0]};
	assign m1_lh = c_s1[31:0] * d_s1[63:32];
	assign m1_hl = c_s1[63:32] * d_s1[31:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			p0_ll_s2 <= m0_ll;
			p1_ll_s2 <= m1_ll;
			p0_x_s2  <= m0_lh + m0_hl;
			p1_x_s2  <= m1_lh + m1_hl;
			op_s2    <= op_s1;
			ent_s2   <= ent_s1;
		end
	end

	// Stage 3: sum mod 2^64, keep the top bits
	assign hsum = p0_ll_s2 + {p0_x_s2, 32'h0} + p1_ll_s2 + {p1_x_s2, 32'h0};

	always_ff @(posedge clk) begin
		if (adv) begin
			top_s3 <= hsum[63 -: BUCKET_BITS];
			op_s3  <= op_s2;
			ent_s3 <= ent_s2;
		end
	end

	// Clamp key_bits and select the bucket
	always_comb begin
		if (key_bits == 4'd0)
			eff = 4'd1;
		else if (key_bits > 4'(MAX_KEY_BITS))
			eff = 4'(MAX_KEY_BITS);
		else
			eff = key_bits;
		shamt = 4'(MAX_KEY_BITS) - eff;
	end

	assign push_data = '{op: op_s3, ent: ent_s3, bucket: top_s3 >> shamt};

endmodule

### hdl/ghct_fifo.sv
module ghct_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ghct_pkg::job_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output ghct_pkg::job_t head
);
	import ghct_pkg::*;

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

	job_t                mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_q, rd_q;
	logic [PTR_BITS:0]   cnt_q;

	assign full  = cnt_q == (PTR_BITS+1)'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_BITS'(QUEUE_DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PTR_BITS'(QUEUE_DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

endmodule

### hdl/ghct_back.sv
`include "guid_keyed_chained_hash_table_assert.svh"

module ghct_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  ghct_pkg::job_t head,
	output logic           pop,
	output logic           ready_for_req,
	output logic           out_valid,
	input  logic           out_ready,
	output ghct_pkg::rsp_t out_data
);
	import ghct_pkg::*;

	back_state_t state_q, state_d;

	// Memories
	logic [IDX_BITS-1:0] head_mem [BUCKET_COUNT];
	logic [IDX_BITS-1:0] link_mem [ENTRY_COUNT];
	entry_t              ent_mem  [ENTRY_COUNT];

	logic                   head_we, link_we, ent_we;
	logic [BUCKET_BITS-1:0] head_wa, head_ra;
	logic [ENTRY_BITS-1:0]  link_wa, ent_wa, ent_ra;
	logic [IDX_BITS-1:0]    head_wd, link_wd, head_rd_q, link_rd_q;
	entry_t                 ent_rd_q;

	job_t                   job_q;
	logic [ENTRY_BITS-1:0]  init_q;
	logic [IDX_BITS-1:0]    cur_q, cur_d, prev_q, prev_d, fh_q, fh_d;
	rsp_t                   res_q, res_d, out_q;
	logic                   out_valid_q, out_load, match;

	assign ready_for_req = state_q != S_INIT;
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

	assign match = ent_rd_q.key_upper == job_q.ent.key_upper &&
		ent_rd_q.key_lower == job_q.ent.key_lower &&
		ent_rd_q.kind == job_q.ent.kind;

	// Sequencer: next state, memory ports and datapath updates
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		out_load = 1'b0;
		head_we  = 1'b0;
		link_we  = 1'b0;
		ent_we   = 1'b0;
		head_wa  = job_q.bucket;
		head_wd  = NONE;
		head_ra  = job_q.bucket;
		link_wa  = cur_q[ENTRY_BITS-1:0];
		link_wd  = fh_q;
		ent_wa   = fh_q[ENTRY_BITS-1:0];
		ent_ra   = cur_q[ENTRY_BITS-1:0];
		cur_d    = cur_q;
		prev_d   = prev_q;
		fh_d     = fh_q;
		res_d    = res_q;
		unique case (state_q)
			S_INIT: begin
				// Clear bucket heads and thread all entries into the free list
				head_we = 1'b1;
				head_wa = init_q[BUCKET_BITS-1:0];
				head_wd = NONE;
				link_we = 1'b1;
				link_wa = init_q;
				link_wd = {1'b0, init_q} + 1'b1;
				if (init_q == '1)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				head_ra = head.bucket;
				ent_ra  = fh_q[ENTRY_BITS-1:0];
				res_d   = '{status: ST_NOT_FOUND, handle_out: '0, bucket_out: head.bucket};
				if (!empty) begin
					pop = 1'b1;
					unique case (head.op)
						OP_INSERT: state_d = S_INS;
						OP_REMOVE, OP_LOOKUP: state_d = S_HEAD;
						default: state_d = S_RESP;
					endcase
				end
			end
			S_INS: begin
				if (fh_q == NONE) begin
					res_d.status = ST_FULL;
				end else begin
					ent_we  = 1'b1;
					link_we = 1'b1;
					link_wa = fh_q[ENTRY_BITS-1:0];
					link_wd = head_rd_q;
					head_we = 1'b1;
					head_wd = fh_q;
					fh_d    = link_rd_q;
					res_d.status     = ST_OK;
					res_d.handle_out = job_q.ent.handle;
				end
				state_d = S_RESP;
			end
			S_HEAD: begin
				// Start the chain walk at the bucket head
				cur_d  = head_rd_q;
				prev_d = NONE;
				ent_ra = head_rd_q[ENTRY_BITS-1:0];
				if (head_rd_q == NONE)
					state_d = S_RESP;
				else
					state_d = S_CMP;
			end
			S_CMP: begin
				ent_ra = link_rd_q[ENTRY_BITS-1:0];
				if (match) begin
					res_d.status     = ST_OK;
					res_d.handle_out = ent_rd_q.handle;
					if (job_q.op == OP_REMOVE) begin
						// Unlink from predecessor or from the bucket head
						if (prev_q == NONE) begin
							head_we = 1'b1;
							head_wd = link_rd_q;
						end else begin
							link_we = 1'b1;
							link_wa = prev_q[ENTRY_BITS-1:0];
							link_wd = link_rd_q;
						end
						state_d = S_FREE;
					end else begin
						state_d = S_RESP;
					end
				end else if (link_rd_q == NONE) begin
					state_d = S_RESP;
				end else begin
					prev_d = cur_q;
					cur_d  = link_rd_q;
				end
			end
			S_FREE: begin
				// Return the removed entry to the free list
				link_we = 1'b1;
				link_wa = cur_q[ENTRY_BITS-1:0];
				link_wd = fh_q;
				fh_d    = cur_q;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_q      <= '0;
			fh_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fh_q    <= fh_d;
			if (state_q == S_INIT)
				init_q <= init_q + 1'b1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Walk registers and result payload
	always_ff @(posedge clk) begin
		cur_q  <= cur_d;
		prev_q <= prev_d;
		res_q  <= res_d;
		if (pop)
			job_q <= head;
		if (out_load)
			out_q <= res_q;
	end

	// Bucket head memory
	always_ff @(posedge clk) begin
		if (head_we)
			head_mem[head_wa] <= head_wd;
		head_rd_q <= head_mem[head_ra];
	end

	// Link memory, read at the same address as the entry memory
	always_ff @(posedge clk) begin
		if (link_we)
			link_mem[link_wa] <= link_wd;
		link_rd_q <= link_mem[ent_ra];
	end

	// Entry memory
	always_ff @(posedge clk) begin
		if (ent_we)
			ent_mem[ent_wa] <= job_q.ent;
		ent_rd_q <= ent_mem[ent_ra];
	end

	`GHCT_ASSERT_NOW(a_cmp_cur_valid, state_q == S_CMP, cur_q != NONE, "chain walk on empty link")
	`GHCT_ASSERT_NOW(a_no_pop_in_init, state_q == S_INIT, !pop, "request taken during clearing pass")
	`GHCT_ASSERT_NEXT(a_load_from_resp, out_load, out_valid_q && state_q == S_IDLE, "result not presented")
	`GHCT_ASSERT_NEXT(a_free_from_remove, state_q == S_FREE, fh_q == $past(cur_q), "free list not updated")

endmodule

### hdl/guid_keyed_chained_hash_table.sv
// GUID-keyed hash table with chained buckets. Requests (insert, remove, lookup) enter a
// three-stage hash front end, wait in a two-deep queue, and are executed by a back-end
// sequencer over single-port-read memories, one request at a time. An insert needs no
// chain walk, while a remove or lookup walks the bucket chain entry by entry (and a
// successful remove also returns the entry to the free list); the chain walk sets the rate.
// After reset a clearing pass initialises the bucket heads and free list; no request is
// accepted until it finishes, though key_bits may be written at any time while idle.
module guid_keyed_chained_hash_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ghct_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output ghct_pkg::rsp_t out_data,
	input  logic           key_bits_we,
	input  logic [3:0]     key_bits_wdata
);
	import ghct_pkg::*;

	logic [3:0] key_bits_q;
	logic       push, full, pop, empty, ready_for_req;
	job_t       push_data, q_head;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			key_bits_q <= 4'(MAX_KEY_BITS);
		else if (key_bits_we)
			key_bits_q <= key_bits_wdata;
	end

	ghct_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.enable    (ready_for_req),
		.key_bits  (key_bits_q),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	ghct_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.head      (q_head)
	);

	ghct_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.empty         (empty),
		.head          (q_head),
		.pop           (pop),
		.ready_for_req (ready_for_req),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data)
	);

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import ghct_pkg::*;

	// Scoreboard: a software copy of the table plus the queue of awaited responses
	class hash_table_scoreboard;
		bit [3:0]  key_bits;
		bit [12:0] bucket_head[BUCKET_COUNT];
		bit [63:0] key_upper[ENTRY_COUNT];
		bit [63:0] key_lower[ENTRY_COUNT];
		bit [2:0]  kind_of[ENTRY_COUNT];
		bit [15:0] handle_of[ENTRY_COUNT];
		bit [12:0] link_of[ENTRY_COUNT];
		bit [12:0] free_head;
		rsp_t      pending_rsp[$];
		int        errors;

		function new();
			key_bits = 4'd12;
			for (int i = 0; i < BUCKET_COUNT; i++) bucket_head[i] = 13'(ENTRY_COUNT);
			for (int i = 0; i < ENTRY_COUNT; i++) link_of[i] = 13'(i + 1);
			free_head = 0;
			errors = 0;
		endfunction

		function bit [11:0] bucket_of(req_t r);
			bit [63:0] h;
			int        eb;
			h = (64'(r.guid_prefix_0) + MIX_C0) * (64'(r.guid_prefix_1) + MIX_C1)
				+ (64'(r.guid_prefix_2) + MIX_C2) * (64'(r.entity_word) + MIX_C3);
			eb = (key_bits < 1) ? 1 : (key_bits > MAX_KEY_BITS) ? MAX_KEY_BITS : key_bits;
			return 12'(h >> (64 - eb));
		endfunction

		// Apply an accepted request to the copy and queue its response
		function void note_request(req_t r);
			bit [11:0] b;
			bit [63:0] up;
			bit [63:0] lo;
			bit [12:0] cur;
			bit [12:0] prv;
			rsp_t      rsp;
			b = bucket_of(r);
			up = {r.guid_prefix_0, r.guid_prefix_1};
			lo = {r.guid_prefix_2, r.entity_word};
			rsp.status = ST_NOT_FOUND;
			rsp.handle_out = 0;
			rsp.bucket_out = b;
			if (r.opcode == OP_INSERT) begin
				if (free_head >= ENTRY_COUNT) begin
					rsp.status = ST_FULL;
				end else begin
					cur = free_head;
					free_head = link_of[cur];
					key_upper[cur] = up;
					key_lower[cur] = lo;
					kind_of[cur] = r.obj_kind;
					handle_of[cur] = r.handle_in;
					link_of[cur] = bucket_head[b];
					bucket_head[b] = cur;
					rsp.status = ST_OK;
					rsp.handle_out = r.handle_in;
				end
			end else if (r.opcode == OP_REMOVE || r.opcode == OP_LOOKUP) begin
				prv = 13'(ENTRY_COUNT);
				cur = bucket_head[b];
				while (cur < ENTRY_COUNT) begin
					if (key_upper[cur] == up && key_lower[cur] == lo
						&& kind_of[cur] == r.obj_kind) begin
						rsp.status = ST_OK;
						rsp.handle_out = handle_of[cur];
						if (r.opcode == OP_REMOVE) begin
							if (prv < ENTRY_COUNT) link_of[prv] = link_of[cur];
							else bucket_head[b] = link_of[cur];
							link_of[cur] = free_head;
							free_head = cur;
						end
						break;
					end
					prv = cur;
					cur = link_of[cur];
				end
			end
			pending_rsp.push_back(rsp);
		endfunction

		task report(string what, int got, int want);
			$display("mismatch %s: got %0d, want %0d", what, got, want);
			errors++;
		endtask

		task check_response(rsp_t got);
			rsp_t want;
			if (pending_rsp.size() == 0) begin
				report("responses outstanding", 1, 0);
			end else begin
				want = pending_rsp.pop_front();
				if (got.status !== want.status) report("status", got.status, want.status);
				if (got.handle_out !== want.handle_out)
					report("handle_out", got.handle_out, want.handle_out);
				if (got.bucket_out !== want.bucket_out)
					report("bucket_out", got.bucket_out, want.bucket_out);
			end
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	req_t       in_data;
	logic       out_valid;
	logic       out_ready;
	rsp_t       out_data;
	logic       key_bits_we;
	logic [3:0] key_bits_wdata;

	hash_table_scoreboard sb;
	longint unsigned cycle_count;
	bit   hold_off;
	req_t recent_keys[$];

	guid_keyed_chained_hash_table DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.key_bits_we    (key_bits_we),
		.key_bits_wdata (key_bits_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 2000000) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Receiver: own stall pattern, with a long hold-off when asked
	initial begin
		int stall_mode;
		int hold_cycles;
		out_ready = 1'b0;
		stall_mode = 0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				hold_cycles = 300;
				out_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_off = 0;
			end
			if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Response sampling and checking
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_response(out_data);
	end

	function automatic req_t random_request(int mode);
		req_t r;
		r.opcode = 2'($urandom_range(0, 2));
		r.guid_prefix_0 = $urandom();
		r.guid_prefix_1 = $urandom();
		r.guid_prefix_2 = $urandom();
		r.entity_word = $urandom();
		r.obj_kind = 3'($urandom_range(0, 7));
		r.handle_in = 16'($urandom());
		// mostly reuse a known key so removes and lookups hit
		if (mode == 0 && recent_keys.size() > 0 && $urandom_range(0, 3) != 0) begin
			req_t k;
			k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
			r.guid_prefix_0 = k.guid_prefix_0;
			r.guid_prefix_1 = k.guid_prefix_1;
			r.guid_prefix_2 = k.guid_prefix_2;
			r.entity_word = k.entity_word;
			if ($urandom_range(0, 7) != 0) r.obj_kind = k.obj_kind;
		end
		if ($urandom_range(0, 40) == 0) r.opcode = OP_RSVD;
		return r;
	endfunction

	// Offer one request and wait for acceptance
	task automatic send_request(req_t r);
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(r);
		if (r.opcode == OP_INSERT) begin
			recent_keys.push_back(r);
			if (recent_keys.size() > 64) void'(recent_keys.pop_front());
		end
	endtask

	task automatic idle_cycles(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Drain responses, then program key_bits
	task automatic write_key_bits(bit [3:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_rsp.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		key_bits_we <= 1'b1;
		key_bits_wdata <= v;
		@(posedge clk);
		key_bits_we <= 1'b0;
		sb.key_bits = v;
	endtask

	task automatic random_phase(int n);
		int burst;
		int i;
		i = 0;
		while (i < n) begin
			burst = $urandom_range(1, 12);
			for (int j = 0; j < burst && i < n; j++) begin
				send_request(random_request($urandom_range(0, 4) == 0));
				i++;
			end
			if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 8));
		end
	endtask

	initial begin
		req_t r;
		sb = new();
		in_valid = 1'b0;
		in_data = '0;
		key_bits_we = 1'b0;
		key_bits_wdata = 4'd0;
		hold_off = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);

		// Directed: field extremes, all opcodes, duplicates, misses
		r = '0;
		send_request(r);
		r.handle_in = 16'hffff;
		r.obj_kind = 3'd7;
		r.guid_prefix_0 = '1; r.guid_prefix_1 = '1;
		r.guid_prefix_2 = '1; r.entity_word = '1;
		send_request(r);
		r.handle_in = 16'h1234;
		send_request(r);                       // duplicate key shadows the older
		r.opcode = OP_LOOKUP; send_request(r);
		r.opcode = OP_REMOVE; send_request(r);
		r.opcode = OP_LOOKUP; send_request(r); // older entry visible again
		r.opcode = OP_REMOVE; send_request(r);
		r.opcode = OP_REMOVE; send_request(r); // miss
		r.obj_kind = 3'd3;
		r.opcode = OP_LOOKUP; send_request(r); // wrong kind
		r.opcode = OP_RSVD; send_request(r);
		r = '0; r.opcode = OP_LOOKUP; send_request(r);
		r.opcode = OP_REMOVE; send_request(r);

		// key_bits extremes, including out-of-range values, entries kept across
		write_key_bits(4'd1);
		random_phase(40);
		write_key_bits(4'd0);
		random_phase(30);
		write_key_bits(4'd15);
		random_phase(30);

		// Long receiver hold-off while requests keep coming
		hold_off = 1;
		random_phase(30);

		write_key_bits(4'd12);
		random_phase(250);
		write_key_bits(4'd4);
		random_phase(80);
		write_key_bits(4'd12);
		random_phase(80);

		in_valid <= 1'b0;
		while (sb.pending_rsp.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
